>>> src/psi_pkg.sv
// Shared widths and codes for the pose interpolator (position lerp, quaternion nlerp).
// No dependencies; imported by psi_mul and pose_interpolate_nlerp.
`timescale 1ns / 1ps
package psi_pkg;

  localparam int POS_W      = 32;
  localparam int QUAT_W     = 16;
  localparam int TIME_W     = 63;
  localparam int SCALE_FRAC = 24;
  localparam int IN_DATA_W  = 224;
  localparam int OUT_DATA_W = 160;
  localparam int STATUS_W   = 3;

  // shared multiplier operands: |diff| below 2^32, scale magnitude below 2^31
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 31;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_ZERO_INT = 3'd1,
    STAT_SAT      = 3'd2,
    STAT_ZERO_Q   = 3'd3,
    STAT_FEW      = 3'd4
  } status_t;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

endpackage

>>> src/psi_mul.sv
// Shared unsigned multiplier with registered product, used for lerps and squares.
// Depends on psi_pkg.
`timescale 1ns / 1ps
module psi_mul (
  input  logic                       clk,
  input  logic [psi_pkg::MUL_A_W-1:0] mul_a,
  input  logic [psi_pkg::MUL_B_W-1:0] mul_b,
  output logic [psi_pkg::PROD_W-1:0]  prod_r
);
  import psi_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

endmodule

>>> src/pose_interpolate_nlerp.sv
// Top level of the pose interpolator: sample store, sequencer and datapath.
// Depends on psi_pkg and psi_mul.
//
//  channel | dir | tdata                                   | tuser
//  in_     | in  | item_time, pos x/y/z, quat x/y/z/w       | opcode
//  out_    | out | pos x/y/z, quat x/y/z/w                 | status
//
// A sample item is stored on acceptance and leaves the block idle. A query runs restoring
// divide steps for the scale, the seven lerps through the shared multiplier,
// normalising shifts, the squares, square-root steps and the divides by the norm.
// One item at a time; in_tready is low while busy.
// Reset (synchronous, rst_n low) clears the samples and the held count.
// A result waits in the output register; a finished query stalls until it is free.
`timescale 1ns / 1ps
module pose_interpolate_nlerp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [62:0] item_time, [94:63] in_pos_x, [126:95] in_pos_y, [158:127] in_pos_z,
  // [174:159] in_quat_x, [190:175] in_quat_y, [206:191] in_quat_z,
  // [222:207] in_quat_w, [223] zero
  input  logic [psi_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] opcode
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [31:0] out_pos_x, [63:32] out_pos_y, [95:64] out_pos_z, [111:96] out_quat_x,
  // [127:112] out_quat_y, [143:128] out_quat_z, [159:144] out_quat_w
  output logic [psi_pkg::OUT_DATA_W-1:0] out_tdata,
  // [2:0] status
  output logic [psi_pkg::STATUS_W-1:0]   out_tuser
);
  import psi_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_PREP  = 13'b0000000000010,
    S_CHK   = 13'b0000000000100,
    S_DIV   = 13'b0000000001000,
    S_LMUL  = 13'b0000000010000,
    S_LADD  = 13'b0000000100000,
    S_NORM  = 13'b0000001000000,
    S_SQ    = 13'b0000010000000,
    S_SQADD = 13'b0000100000000,
    S_SQRT  = 13'b0001000000000,
    S_QINIT = 13'b0010000000000,
    S_QSTEP = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  // sample store
  logic signed [POS_W-1:0]  older_pos_r [3];
  logic signed [POS_W-1:0]  newer_pos_r [3];
  logic signed [QUAT_W-1:0] older_quat_r [4];
  logic signed [QUAT_W-1:0] newer_quat_r [4];
  logic [TIME_W-1:0]        older_time_r, newer_time_r;
  logic [1:0]               held_r;

  // query working registers
  logic [TIME_W-1:0]  t_r, b_r;
  logic               neg_r, lneg_r;
  logic [63:0]        rem_r;
  logic [69:0]        d_r;
  logic [30:0]        m_r;
  logic [4:0]         cnt_r;
  logic [2:0]         idx_r;
  status_t            status_r;
  logic signed [26:0] cq_r [4];
  logic [29:0]        mq_r [4];
  logic signed [POS_W-1:0]  pres_r [3];
  logic signed [QUAT_W-1:0] qres_r [4];
  logic [62:0]        sum_r, v_r, r_r, bit_r;
  logic [30:0]        nrm_r;
  logic [30:0]        qrem_r;
  logic [14:0]        qnum_r;
  logic [14:0]        qv_r;

  logic                    out_tvalid_r;
  logic [OUT_DATA_W-1:0]   out_data_r;
  logic [STATUS_W-1:0]     out_user_r;

  logic in_acc, out_free;
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign out_free   = ~out_tvalid_r | out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // scale set-up
  logic [TIME_W-1:0] a_abs, b_abs;
  logic              t_lt, n_lt;
  assign t_lt  = t_r < older_time_r;
  assign n_lt  = newer_time_r < older_time_r;
  assign a_abs = t_lt ? older_time_r - t_r : t_r - older_time_r;
  assign b_abs = n_lt ? older_time_r - newer_time_r : newer_time_r - older_time_r;

  // divide step: integer phase compares against shifted divisor, fraction phase shifts rem
  logic [64:0] div_x, div_diff;
  logic        div_ge;
  assign div_x    = (cnt_r < 5'd7) ? {1'b0, rem_r} : {rem_r, 1'b0};
  assign div_ge   = {5'b0, div_x} >= d_r;
  assign div_diff = div_x - d_r[64:0];

  // lerp operand select
  logic signed [POS_W-1:0] old_v, new_v;
  logic signed [POS_W:0]   ldiff;
  logic [MUL_A_W-1:0]      lmag;
  always_comb begin
    if (idx_r < 3'd4) begin
      old_v = POS_W'(older_quat_r[idx_r[1:0]]);
      new_v = POS_W'(newer_quat_r[idx_r[1:0]]);
    end else begin
      old_v = older_pos_r[idx_r[1:0]];
      new_v = newer_pos_r[idx_r[1:0]];
    end
  end
  assign ldiff = (POS_W+1)'(new_v) - (POS_W+1)'(old_v);
  assign lmag  = ldiff[POS_W] ? MUL_A_W'(-ldiff) : MUL_A_W'(ldiff);

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod_r;
  assign mul_a = (state_r == S_LMUL) ? lmag : MUL_A_W'(mq_r[idx_r[1:0]]);
  assign mul_b = (state_r == S_LMUL) ? m_r  : MUL_B_W'(mq_r[idx_r[1:0]]);

  psi_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  // round half away on magnitude, then apply sign
  logic [PROD_W:0]   rsum;
  logic [40:0]       lp;
  logic signed [41:0] lres;
  logic signed [POS_W-1:0] lclamp;
  assign rsum = {1'b0, prod_r} + (PROD_W+1)'(1 << (SCALE_FRAC - 1));
  assign lp   = rsum[SCALE_FRAC+40:SCALE_FRAC];
  assign lres = lneg_r ? 42'(old_v) - 42'(lp) : 42'(old_v) + 42'(lp);
  always_comb begin
    if (lres > 42'sd2147483647)       lclamp = {1'b0, {(POS_W-1){1'b1}}};
    else if (lres < -42'sd2147483648) lclamp = {1'b1, {(POS_W-1){1'b0}}};
    else                              lclamp = lres[POS_W-1:0];
  end
  logic [26:0] cq_abs;
  assign cq_abs = lres[26] ? 27'(-lres[26:0]) : lres[26:0];

  // normalise
  logic mq_any, mq_top;
  assign mq_any = |(mq_r[0] | mq_r[1] | mq_r[2] | mq_r[3]);
  assign mq_top = mq_r[0][29] | mq_r[1][29] | mq_r[2][29] | mq_r[3][29];

  // square root step
  logic [62:0] sq_trial;
  logic        sq_ge;
  assign sq_trial = r_r + bit_r;
  assign sq_ge    = v_r >= sq_trial;

  // divide by the norm
  logic [44:0] qn;
  logic [31:0] qx;
  logic        q_ge;
  logic [14:0] qv_fin;
  assign qn     = {1'b0, mq_r[idx_r[1:0]], 14'b0} + 45'(nrm_r >> 1);
  assign qx     = {qrem_r, qnum_r[14]};
  assign q_ge   = qx >= {1'b0, nrm_r};
  assign qv_fin = {qv_r[13:0], q_ge};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc && in_tuser == OP_QUERY) state_nxt = S_PREP;
      S_PREP:  begin
        if (held_r < 2'd2 || newer_time_r == older_time_r) state_nxt = S_DONE;
        else state_nxt = S_CHK;
      end
      S_CHK:   state_nxt = ({1'b0, rem_r} >= {b_r, 7'b0}) ? S_DONE : S_DIV;
      S_DIV:   if (cnt_r == 5'd30) state_nxt = S_LMUL;
      S_LMUL:  state_nxt = S_LADD;
      S_LADD:  state_nxt = (idx_r == 3'd6) ? S_NORM : S_LMUL;
      S_NORM:  begin
        if (!mq_any) state_nxt = S_DONE;
        else if (mq_top) state_nxt = S_SQ;
      end
      S_SQ:    state_nxt = S_SQADD;
      S_SQADD: state_nxt = (idx_r == 3'd3) ? S_SQRT : S_SQ;
      S_SQRT:  if (bit_r[0]) state_nxt = S_QINIT;
      S_QINIT: state_nxt = S_QSTEP;
      S_QSTEP: if (cnt_r == 5'd14) state_nxt = (idx_r == 3'd3) ? S_DONE : S_QINIT;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      held_r       <= 2'd0;
      older_time_r <= '0;
      newer_time_r <= '0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        older_pos_r[i] <= '0;
        newer_pos_r[i] <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        older_quat_r[i] <= '0;
        newer_quat_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (in_acc && in_tuser == OP_SAMPLE) begin
        older_pos_r  <= newer_pos_r;
        older_quat_r <= newer_quat_r;
        older_time_r <= newer_time_r;
        newer_time_r <= in_tdata[62:0];
        newer_pos_r[0]  <= in_tdata[94:63];
        newer_pos_r[1]  <= in_tdata[126:95];
        newer_pos_r[2]  <= in_tdata[158:127];
        newer_quat_r[0] <= in_tdata[174:159];
        newer_quat_r[1] <= in_tdata[190:175];
        newer_quat_r[2] <= in_tdata[206:191];
        newer_quat_r[3] <= in_tdata[222:207];
        if (held_r < 2'd2) held_r <= held_r + 2'd1;
      end
      if (state_r == S_DONE && out_free) out_tvalid_r <= 1'b1;
      else if (out_tready)              out_tvalid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        t_r      <= in_tdata[62:0];
        status_r <= STAT_OK;
      end
      S_PREP: begin
        if (held_r < 2'd2) status_r <= STAT_FEW;
        else if (newer_time_r == older_time_r) status_r <= STAT_ZERO_INT;
        rem_r <= 64'(a_abs);
        b_r   <= b_abs;
        neg_r <= t_lt ^ n_lt;
      end
      S_CHK: begin
        if ({1'b0, rem_r} >= {b_r, 7'b0}) status_r <= STAT_SAT;
        d_r   <= {1'b0, b_r, 6'b0};
        cnt_r <= '0;
        m_r   <= '0;
      end
      S_DIV: begin
        rem_r <= div_ge ? div_diff[63:0] : div_x[63:0];
        m_r   <= {m_r[29:0], div_ge};
        if (cnt_r < 5'd6) d_r <= d_r >> 1;
        cnt_r <= cnt_r + 5'd1;
        idx_r <= '0;
      end
      S_LMUL: lneg_r <= ldiff[POS_W] ^ neg_r;
      S_LADD: begin
        if (idx_r < 3'd4) begin
          cq_r[idx_r[1:0]] <= lres[26:0];
          mq_r[idx_r[1:0]] <= 30'(cq_abs);
        end else begin
          pres_r[idx_r[1:0]] <= lclamp;
        end
        idx_r <= idx_r + 3'd1;
      end
      S_NORM: begin
        if (!mq_any) status_r <= STAT_ZERO_Q;
        else if (!mq_top) begin
          for (int i = 0; i < 4; i++) mq_r[i] <= {mq_r[i][28:0], 1'b0};
        end
        idx_r <= '0;
        sum_r <= '0;
      end
      S_SQ: ;
      S_SQADD: begin
        sum_r <= sum_r + prod_r[62:0];
        v_r   <= sum_r + prod_r[62:0];
        r_r   <= '0;
        bit_r <= 63'(1) << 62;
        idx_r <= (idx_r == 3'd3) ? 3'd0 : idx_r + 3'd1;
      end
      S_SQRT: begin
        if (sq_ge) begin
          v_r <= v_r - sq_trial;
          r_r <= (r_r >> 1) + bit_r;
          nrm_r <= 31'((r_r >> 1) + bit_r);
        end else begin
          r_r <= r_r >> 1;
          nrm_r <= 31'(r_r >> 1);
        end
        bit_r <= bit_r >> 2;
      end
      S_QINIT: begin
        qrem_r <= {1'b0, qn[44:15]};
        qnum_r <= qn[14:0];
        qv_r   <= '0;
        cnt_r  <= '0;
      end
      S_QSTEP: begin
        qrem_r <= q_ge ? 31'(qx - {1'b0, nrm_r}) : qx[30:0];
        qnum_r <= {qnum_r[13:0], 1'b0};
        qv_r   <= qv_fin;
        cnt_r  <= cnt_r + 5'd1;
        if (cnt_r == 5'd14) begin
          qres_r[idx_r[1:0]] <= cq_r[idx_r[1:0]][26] ? -QUAT_W'(qv_fin) : QUAT_W'(qv_fin);
          idx_r <= idx_r + 3'd1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_user_r <= status_r;
          if (status_r != STAT_OK) begin
            out_data_r <= {older_quat_r[3], older_quat_r[2], older_quat_r[1], older_quat_r[0],
                           older_pos_r[2], older_pos_r[1], older_pos_r[0]};
          end else begin
            out_data_r <= {qres_r[3], qres_r[2], qres_r[1], qres_r[0],
                           pres_r[2], pres_r[1], pres_r[0]};
          end
        end
      end
      default: ;
    endcase
  end

endmodule

>>> test/tb_pose_interpolate_nlerp.sv
// Self-checking bench for pose_interpolate_nlerp: directed table, then random sample/query mix.
// Depends on psi_pkg for widths, opcodes and status codes; predicts every result itself.
`timescale 1ns / 1ps
module tb_pose_interpolate_nlerp;
  import psi_pkg::*;

  localparam int N_RANDOM  = 800;
  localparam int HOLD_LEN  = 3000;   // long receiver hold-off, cycles
  localparam int DRAIN_CYC = 400;    // extra wait after the expected queue empties

  typedef struct packed {
    logic signed [QUAT_W-1:0] qw, qz, qy, qx;
    logic signed [POS_W-1:0]  pz, py, px;
  } pose_t;

  typedef struct {
    pose_t   pose;
    status_t status;
  } interp_res_t;

  typedef struct {
    logic              op;
    logic [TIME_W-1:0] tm;
    pose_t             pose;
    bit                typed;       // status read off by hand
    status_t           typed_stat;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;

  pose_interpolate_nlerp u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // time, pos x/y/z, quat x/y/z/w, zero pad
    .in_tuser  (in_tuser),   // opcode
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // pos x/y/z, quat x/y/z/w
    .out_tuser (out_tuser)   // status
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // generous fixed limit, far beyond the slowest legal run
  initial begin
    #4000000;
    $display("pose_interpolate_nlerp: mismatch");
    $finish;
  end

  // ---- predictor state: two pose samples and a held count ----
  pose_t             old_pose, new_pose;
  logic [TIME_W-1:0] old_time, new_time;
  int unsigned       held;

  interp_res_t pose_q[$];   // expected interpolated poses, oldest first
  stim_row_t   rows[$];
  int          n_fail = 0;
  int          items_sent = 0;
  int          sender_idle_pct = 0;
  int          rcv_stall_pct = 0;

  function automatic logic [63:0] mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // a + (b - a) * s / 2^24, half away from zero
  function automatic longint lerp(longint a, longint b, longint s);
    logic [63:0] md, ms, hi, lo, p;
    md = mag(b - a);
    ms = mag(s);
    hi = md >> SCALE_FRAC;
    lo = md & ((64'd1 << SCALE_FRAC) - 1);
    p  = hi * ms + ((lo * ms + (64'd1 << (SCALE_FRAC - 1))) >> SCALE_FRAC);
    return ((b - a < 0) != (s < 0)) ? a - longint'(p) : a + longint'(p);
  endfunction

  function automatic interp_res_t interp_pose(logic [TIME_W-1:0] t);
    interp_res_t res;
    logic [63:0] a, b, q, r, m, mx, sum, nrm, v;
    logic [63:0] mq[4];
    longint      cq[4], oq[4], nq[4], op[3], np[3], s, p;
    bit          neg;
    int          top;
    res.pose   = old_pose;   // error output is the older sample
    res.status = STAT_OK;
    oq = '{old_pose.qx, old_pose.qy, old_pose.qz, old_pose.qw};
    nq = '{new_pose.qx, new_pose.qy, new_pose.qz, new_pose.qw};
    op = '{old_pose.px, old_pose.py, old_pose.pz};
    np = '{new_pose.px, new_pose.py, new_pose.pz};
    if (held < 2) begin
      res.status = STAT_FEW;
      return res;
    end
    if (new_time == old_time) begin
      res.status = STAT_ZERO_INT;
      return res;
    end
    a   = t >= old_time ? t - old_time : old_time - t;
    b   = new_time >= old_time ? new_time - old_time : old_time - new_time;
    neg = (t < old_time) != (new_time < old_time);
    q   = a / b;
    r   = a % b;
    if (q >= 128) begin
      res.status = STAT_SAT;
      return res;
    end
    m = q;
    for (int i = 0; i < SCALE_FRAC; i++) begin
      r = r << 1;
      m = m << 1;
      if (r >= b) begin
        r = r - b;
        m = m | 64'd1;
      end
    end
    s  = neg ? -longint'(m) : longint'(m);
    mx = 0;
    for (int i = 0; i < 4; i++) begin
      cq[i] = lerp(oq[i], nq[i], s);
      mq[i] = mag(cq[i]);
      if (mq[i] > mx) mx = mq[i];
    end
    if (mx == 0) begin
      res.status = STAT_ZERO_Q;
      return res;
    end
    // normalise so the largest magnitude tops out at bit 29
    top = 0;
    while ((mx >> top) > 1) top++;
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      if (top > 29) mq[i] = mq[i] >> (top - 29);
      else mq[i] = mq[i] << (29 - top);
      sum = sum + mq[i] * mq[i];
    end
    nrm = isqrt(sum);
    for (int i = 0; i < 4; i++) begin
      v = ((mq[i] << (QUAT_W - 2)) + nrm / 2) / nrm;
      cq[i] = cq[i] < 0 ? -longint'(v) : longint'(v);
    end
    res.pose.qx = QUAT_W'(cq[0]);
    res.pose.qy = QUAT_W'(cq[1]);
    res.pose.qz = QUAT_W'(cq[2]);
    res.pose.qw = QUAT_W'(cq[3]);
    for (int i = 0; i < 3; i++) begin
      p = lerp(op[i], np[i], s);
      if (p < -(longint'(1) <<< (POS_W - 1))) p = -(longint'(1) <<< (POS_W - 1));
      if (p > (longint'(1) <<< (POS_W - 1)) - 1) p = (longint'(1) <<< (POS_W - 1)) - 1;
      op[i] = p;
    end
    res.pose.px = POS_W'(op[0]);
    res.pose.py = POS_W'(op[1]);
    res.pose.pz = POS_W'(op[2]);
    return res;
  endfunction

  // predictor step for one accepted item
  task automatic take_item(stim_row_t row);
    interp_res_t res;
    if (row.op == OP_SAMPLE) begin
      old_pose = new_pose;
      new_pose = row.pose;
      old_time = new_time;
      new_time = row.tm;
      if (held < 2) held++;
    end else begin
      res = interp_pose(row.tm);
      if (row.typed) res.status = row.typed_stat;
      pose_q.push_back(res);
    end
  endtask

  task automatic add_row(logic op, logic [TIME_W-1:0] tm, pose_t ps,
                         bit typed = 0, status_t st = STAT_OK);
    stim_row_t row;
    row.op         = op;
    row.tm         = tm;
    row.pose       = ps;
    row.typed      = typed;
    row.typed_stat = st;
    rows.push_back(row);
  endtask

  function automatic pose_t mk_pose(longint x, longint y, longint z,
                                    longint qx, longint qy, longint qz, longint qw);
    pose_t ps;
    ps.px = POS_W'(x); ps.py = POS_W'(y); ps.pz = POS_W'(z);
    ps.qx = QUAT_W'(qx); ps.qy = QUAT_W'(qy); ps.qz = QUAT_W'(qz); ps.qw = QUAT_W'(qw);
    return ps;
  endfunction

  function automatic pose_t rand_pose();
    pose_t ps;
    ps = {$urandom, $urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(3) != 0) begin
      // mostly near-unit quaternions and modest positions
      ps.qx = QUAT_W'($signed($urandom_range(32768)) - 16384);
      ps.qy = QUAT_W'($signed($urandom_range(32768)) - 16384);
      ps.qz = QUAT_W'($signed($urandom_range(32768)) - 16384);
      ps.qw = QUAT_W'($signed($urandom_range(32768)) - 16384);
      ps.px = $signed(ps.px) >>> $urandom_range(16);
      ps.py = $signed(ps.py) >>> $urandom_range(16);
      ps.pz = $signed(ps.pz) >>> $urandom_range(16);
    end
    return ps;
  endfunction

  // drive one item and wait for its handshake
  task automatic send_item(stim_row_t row);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= row.op;
    in_tdata  <= {1'b0, row.pose, row.tm};
    do @(posedge clk); while (!in_tready);
    take_item(row);
    items_sent++;
  endtask

  // ---- result side: stalls and a single long hold-off ----
  int hold_left = 0;
  bit hold_done = 0;

  always @(posedge clk) begin
    if (!hold_done && items_sent >= 60) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // compare every accepted result with the oldest expected pose
  always @(posedge clk) begin
    interp_res_t exp_r;
    pose_t       got;
    bit          bad;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pose_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) $display("unexpected result: data %h status %0d", out_tdata, out_tuser);
      end else begin
        exp_r = pose_q.pop_front();
        bad = (got.px != exp_r.pose.px) || (got.py != exp_r.pose.py) ||
              (got.pz != exp_r.pose.pz) || (got.qx != exp_r.pose.qx) ||
              (got.qy != exp_r.pose.qy) || (got.qz != exp_r.pose.qz) ||
              (got.qw != exp_r.pose.qw) || (out_tuser != exp_r.status);
        if (bad) begin
          n_fail++;
          if (n_fail <= 10) begin
            $display("result mismatch: status exp %0d got %0d", exp_r.status, out_tuser);
            $display("  pos exp %0d %0d %0d got %0d %0d %0d", exp_r.pose.px, exp_r.pose.py,
                     exp_r.pose.pz, got.px, got.py, got.pz);
            $display("  quat exp %0d %0d %0d %0d got %0d %0d %0d %0d", exp_r.pose.qx,
                     exp_r.pose.qy, exp_r.pose.qz, exp_r.pose.qw, got.qx, got.qy, got.qz,
                     got.qw);
          end
        end
      end
    end
  end

  initial begin
    stim_row_t         row;
    logic [TIME_W-1:0] last_t;
    pose_t             unit_x, neg_x, unit_w, junk;
    int                wait_cyc;
    old_pose = '0; new_pose = '0; old_time = '0; new_time = '0; held = 0;
    unit_x = mk_pose(0, 0, 0, 16384, 0, 0, 0);
    neg_x  = mk_pose(0, 0, 0, -16384, 0, 0, 0);
    unit_w = mk_pose(65536, -65536, 1, 0, 0, 0, 16384);
    junk   = rand_pose();

    // directed table
    add_row(OP_QUERY, 0, junk, 1, STAT_FEW);                 // nothing loaded yet
    add_row(OP_SAMPLE, 100, mk_pose(2147483647, 2147483647, 2147483647,
                                    32767, 32767, 32767, 32767));
    add_row(OP_QUERY, 100, junk, 1, STAT_FEW);               // only one sample
    add_row(OP_SAMPLE, 100, mk_pose(-2147483648, -2147483648, -2147483648,
                                    -32768, -32768, -32768, -32768));
    add_row(OP_QUERY, 150, junk, 1, STAT_ZERO_INT);          // equal timestamps
    add_row(OP_SAMPLE, 1100, unit_x);
    add_row(OP_QUERY, 600, junk);                            // midpoint
    add_row(OP_QUERY, 128100, junk, 1, STAT_SAT);            // scale exactly 128
    add_row(OP_QUERY, 128099, junk);                         // scale just under 128
    add_row(OP_QUERY, 0, junk);                              // extrapolate backwards
    add_row(OP_SAMPLE, 2100, unit_x);
    add_row(OP_QUERY, 1600, junk);
    add_row(OP_SAMPLE, 3100, neg_x);
    add_row(OP_QUERY, 2600, junk, 1, STAT_ZERO_Q);           // opposite quats cancel
    add_row(OP_SAMPLE, 63'h7fff_ffff_ffff_ffff, unit_w);      // largest timestamp
    add_row(OP_QUERY, 0, junk);
    add_row(OP_SAMPLE, 0, unit_x);                           // newer older than older
    add_row(OP_QUERY, 63'h7fff_ffff_ffff_ffff, junk);
    add_row(OP_SAMPLE, 0, mk_pose(2147483647, -2147483648, 0, 0, 16384, 0, 0));
    add_row(OP_SAMPLE, 1, mk_pose(-2147483648, 2147483647, 0, 0, 16384, 0, 0));
    add_row(OP_QUERY, 100, junk);                            // position saturates
    add_row(OP_QUERY, 1, junk);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_item(rows[i]);

    // random part: phases of idling on each side
    last_t = 5000;
    for (int n = 0; n < N_RANDOM; n++) begin
      case (n * 4 / N_RANDOM)
        0: begin sender_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin sender_idle_pct = 88; rcv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  rcv_stall_pct = 88; end
        default: begin sender_idle_pct = 23; rcv_stall_pct = 23; end
      endcase
      row.typed = 0;
      row.typed_stat = STAT_OK;
      row.pose = rand_pose();
      row.op = 1'($urandom_range(1));
      if (row.op == OP_SAMPLE) begin
        case ($urandom_range(9))
          0: row.tm = last_t;                                   // equal timestamps, zero interval
          1: row.tm = TIME_W'({$urandom, $urandom});            // anywhere
          2: row.tm = last_t - $urandom_range(2000, 1);
          default: row.tm = last_t + $urandom_range(5000, 1);
        endcase
        last_t = row.tm;
      end else begin
        case ($urandom_range(9))
          0: row.tm = TIME_W'({$urandom, $urandom});
          1: row.tm = last_t + $urandom_range(400000);
          default: row.tm = last_t + $urandom_range(8000) - 6000;
        endcase
      end
      send_item(row);
    end
    in_tvalid <= 1'b0;

    wait_cyc = 0;
    while (pose_q.size() != 0 && wait_cyc < 200000) begin
      @(posedge clk);
      wait_cyc++;
    end
    repeat (DRAIN_CYC) @(posedge clk);
    if (n_fail == 0 && pose_q.size() == 0) begin
      $display("pose_interpolate_nlerp: match");
    end else begin
      $display("pose_interpolate_nlerp: mismatch");
    end
    $finish;
  end

endmodule
